FILE: rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sfr_pkg
// Shared types, constants and helpers of the stream find-and-replace core.
// ============================================================================
package sfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int CNT_W           = 4;
    localparam int IDX_W           = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int OUTPUT_LIMIT_W  = 16;
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FIND_PATTERN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIND_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_PATTERN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT    = 3'd5;

    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_CASE    = 8'h20;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] find_pattern;
        logic [CNT_W-1:0]      find_length;
        logic [CFG_DATA_W-1:0] replace_pattern;
        logic [CNT_W-1:0]      replace_length;
        logic                  ignore_case;
    } t_cfg;

    // one entry of the command queue: text bytes first, then replacement
    typedef struct packed {
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] text;
        logic [CNT_W-1:0]                   shift_cnt;
        logic [CNT_W-1:0]                   emit_cnt;
        logic                               last;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic              byte_present;
        logic              result_last;
    } t_result;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                   input logic ic);
        logic [BYTE_W-1:0] r;
        r = c;
        if (ic && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            r = c + ASCII_CASE;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/stream_find_and_replace_core.sv
`timescale 1ns / 1ps
// ============================================================================
// stream_find_and_replace_core
// Streaming substring replace with optional case folding and output limit.
// ============================================================================
// Input side is a queue: a text word is taken when push is high and full is
// low, with i_text_last on the final byte of a text. Result side is a queue:
// while empty is low the oldest result word is on o_result_*, taken on pop.
// Configuration must be written through i_cfg_we / i_cfg_index / i_cfg_data
// only while no text word is in flight; the core does not enforce this.
// An input word's command is registered in the command queue and its results
// in the result queue. Input: one word per cycle while full is low; the back
// stage emits one result word per cycle while the result queue has room, so a
// word that expands to n results (a replacement or a flush, up to 8) holds the
// back stage for n result words while the 4-deep command queue keeps taking input.
// Reset clears the pending window, the emitted count, both queues and all
// configuration registers. When pop stays low the result queue fills, the
// back stage holds, the command queue fills and full rises.
// ============================================================================
module stream_find_and_replace_core #(
    parameter int MAX_FIND_BYTES    = 8,
    parameter int MAX_REPLACE_BYTES = 8,
    parameter int LIMIT_BITS        = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_text_last,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_result_byte,
    output logic                            o_byte_present,
    output logic                            o_result_last,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int LIM_IN_W = (LIMIT_BITS < sfr_pkg::OUTPUT_LIMIT_W) ?
                              LIMIT_BITS : sfr_pkg::OUTPUT_LIMIT_W;
    localparam int CMD_W    = $bits(sfr_pkg::t_cmd);
    localparam int RES_W    = $bits(sfr_pkg::t_result);

    sfr_pkg::t_cfg         r_cfg;
    logic [LIMIT_BITS-1:0] r_output_limit;

    logic                  accept;
    logic                  cmd_push;
    sfr_pkg::t_cmd         cmd_in;
    logic [CMD_W-1:0]      cmd_head_bits;
    sfr_pkg::t_cmd         cmd_head;
    logic                  cmd_empty;
    logic                  cmd_pop;
    logic                  res_push;
    sfr_pkg::t_result      res_in;
    logic                  res_full;
    logic [RES_W-1:0]      res_head_bits;
    sfr_pkg::t_result      res_head;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg          <= '0;
            r_output_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfr_pkg::CFG_FIND_PATTERN: begin
                    r_cfg.find_pattern <= i_cfg_data;
                end
                sfr_pkg::CFG_FIND_LENGTH: begin
                    r_cfg.find_length <= i_cfg_data[sfr_pkg::CNT_W-1:0];
                end
                sfr_pkg::CFG_REPLACE_PATTERN: begin
                    r_cfg.replace_pattern <= i_cfg_data;
                end
                sfr_pkg::CFG_REPLACE_LENGTH: begin
                    r_cfg.replace_length <= i_cfg_data[sfr_pkg::CNT_W-1:0];
                end
                sfr_pkg::CFG_IGNORE_CASE: begin
                    r_cfg.ignore_case <= i_cfg_data[0];
                end
                sfr_pkg::CFG_OUTPUT_LIMIT: begin
                    r_output_limit <= LIMIT_BITS'(i_cfg_data[LIM_IN_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    sfr_front #(
        .MAX_FIND_BYTES    (MAX_FIND_BYTES),
        .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES),
        .LIMIT_BITS        (LIMIT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_text_byte    (i_text_byte),
        .i_text_last    (i_text_last),
        .i_cfg          (r_cfg),
        .i_output_limit (r_output_limit),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in)
    );

    sfr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (sfr_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head_bits),
        .o_empty (cmd_empty)
    );

    assign cmd_head = cmd_head_bits;

    sfr_back #(
        .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (!cmd_empty),
        .i_cmd             (cmd_head),
        .i_replace_pattern (r_cfg.replace_pattern),
        .i_out_full        (res_full),
        .o_cmd_pop         (cmd_pop),
        .o_res_push        (res_push),
        .o_res             (res_in)
    );

    sfr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (sfr_pkg::OUT_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head_bits),
        .o_empty (empty)
    );

    assign res_head       = res_head_bits;
    assign o_result_byte  = res_head.result_byte;
    assign o_byte_present = res_head.byte_present;
    assign o_result_last  = res_head.result_last;

endmodule

FILE: rtl/core/sfr_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// sfr_fifo
// Small register queue with count; used between front and back and at the
// result side.
// ============================================================================
module sfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [AW-1:0]               r_wr;
    logic [AW-1:0]               r_rd;
    logic [CW-1:0]               r_cnt;
    logic                        wr_en;
    logic                        rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/sfr_front.sv
`timescale 1ns / 1ps
// ============================================================================
// sfr_front
// Takes one text byte per cycle while accepted, matches the pending window
// against the find pattern and queues a command naming the bytes to emit.
// ============================================================================
module sfr_front #(
    parameter int MAX_FIND_BYTES    = 8,
    parameter int MAX_REPLACE_BYTES = 8,
    parameter int LIMIT_BITS        = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [7:0]                i_text_byte,
    input  logic                      i_text_last,
    input  sfr_pkg::t_cfg             i_cfg,
    input  logic [LIMIT_BITS-1:0]     i_output_limit,
    output logic                      o_cmd_push,
    output sfr_pkg::t_cmd             o_cmd
);

    localparam int CW = sfr_pkg::CNT_W;
    localparam int XD = MAX_FIND_BYTES + 1;

    logic [MAX_FIND_BYTES-1:0][7:0] r_win;
    logic [MAX_FIND_BYTES-1:0][7:0] n_win;
    logic [CW-1:0]                  r_pc;
    logic [CW-1:0]                  n_pc;
    logic [LIMIT_BITS-1:0]          r_ec;
    logic [LIMIT_BITS-1:0]          n_ec;

    logic [XD-1:0][7:0]             x;
    logic [XD-1:0][7:0]             xf;
    logic [MAX_FIND_BYTES-1:0][7:0] pf;
    logic [CW-1:0]                  flen;
    logic [CW-1:0]                  rlen;
    logic [CW-1:0]                  x_len;
    logic [CW-1:0]                  kmin;
    logic [CW-1:0]                  sel_k;
    logic [CW-1:0]                  sel_len;
    logic [CW-1:0]                  shift_cnt;
    logic [CW-1:0]                  rem_cap;
    logic [CW-1:0]                  total_cap;
    logic [CW-1:0]                  emit_cnt;
    logic [CW:0]                    total;
    logic                           rep;
    logic [LIMIT_BITS-1:0]          lim_m1;
    logic [LIMIT_BITS-1:0]          diff;
    logic [LIMIT_BITS:0]            ec_sum;

    // window plus the new byte, folded for compare
    always_comb begin
        for (int i = 0; i < MAX_FIND_BYTES; i++) begin
            x[i] = (CW'(i) < r_pc) ? r_win[i] : i_text_byte;
            pf[i] = sfr_pkg::fold_byte(i_cfg.find_pattern[8*i +: 8], i_cfg.ignore_case);
        end
        x[XD-1] = i_text_byte;
        for (int i = 0; i < XD; i++) begin
            xf[i] = sfr_pkg::fold_byte(x[i], i_cfg.ignore_case);
        end
    end

    assign flen  = (i_cfg.find_length > CW'(MAX_FIND_BYTES)) ?
                   CW'(MAX_FIND_BYTES) : i_cfg.find_length;
    assign rlen  = (i_cfg.replace_length > CW'(MAX_REPLACE_BYTES)) ?
                   CW'(MAX_REPLACE_BYTES) : i_cfg.replace_length;
    assign x_len = r_pc + 1'b1;
    assign kmin  = (r_pc >= CW'(MAX_FIND_BYTES)) ? CW'(1) : CW'(0);

    // lowest start offset whose tail is a prefix of the pattern
    always_comb begin
        logic          ok;
        logic [CW-1:0] len_k;
        sel_k = x_len;
        for (int k = XD; k >= 0; k--) begin
            len_k = x_len - CW'(k);
            ok    = 1'b1;
            for (int i = 0; i < MAX_FIND_BYTES; i++) begin
                if (k + i < XD) begin
                    if (CW'(i) < len_k && xf[k+i] != pf[i]) begin
                        ok = 1'b0;
                    end
                end
            end
            if (CW'(k) >= kmin && CW'(k) <= x_len && len_k <= flen && ok) begin
                sel_k = CW'(k);
            end
        end
    end

    assign sel_len = x_len - sel_k;
    assign rep     = (flen != '0) && (sel_len == flen);

    always_comb begin
        n_pc = '0;
        if (flen == '0 || i_text_last) begin
            shift_cnt = rep ? sel_k : x_len;
        end else if (rep) begin
            shift_cnt = sel_k;
        end else begin
            shift_cnt = sel_k;
            n_pc      = sel_len;
        end
        if (i_text_last) begin
            n_pc = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_FIND_BYTES; i++) begin
            n_win[i] = r_win[i];
            for (int k = 0; k <= XD; k++) begin
                if (i + k < XD) begin
                    if (CW'(k) == sel_k) begin
                        n_win[i] = x[i+k];
                    end
                end
            end
        end
    end

    // output limit and per-byte result cap
    assign total  = {1'b0, shift_cnt} + (rep ? {1'b0, rlen} : '0);
    assign lim_m1 = i_output_limit - 1'b1;
    assign diff   = lim_m1 - r_ec;

    always_comb begin
        if (i_output_limit == '0) begin
            rem_cap = CW'(sfr_pkg::MAX_RESULTS);
        end else if (r_ec >= lim_m1) begin
            rem_cap = '0;
        end else if (diff > LIMIT_BITS'(sfr_pkg::MAX_RESULTS)) begin
            rem_cap = CW'(sfr_pkg::MAX_RESULTS);
        end else begin
            rem_cap = diff[CW-1:0];
        end
        total_cap = (total > (CW+1)'(sfr_pkg::MAX_RESULTS)) ?
                    CW'(sfr_pkg::MAX_RESULTS) : total[CW-1:0];
        emit_cnt  = (total_cap < rem_cap) ? total_cap : rem_cap;
    end

    assign ec_sum = {1'b0, r_ec} + (LIMIT_BITS+1)'(emit_cnt);

    always_comb begin
        if (i_text_last) begin
            n_ec = '0;
        end else if (ec_sum[LIMIT_BITS]) begin
            n_ec = '1;
        end else begin
            n_ec = ec_sum[LIMIT_BITS-1:0];
        end
    end

    always_comb begin
        o_cmd = '0;
        for (int j = 0; j < sfr_pkg::MAX_RESULTS; j++) begin
            if (j < XD) begin
                o_cmd.text[j] = x[j];
            end
        end
        o_cmd.shift_cnt = (shift_cnt > CW'(sfr_pkg::MAX_RESULTS)) ?
                          CW'(sfr_pkg::MAX_RESULTS) : shift_cnt;
        o_cmd.emit_cnt  = emit_cnt;
        o_cmd.last      = i_text_last;
    end

    assign o_cmd_push = i_accept && (emit_cnt != '0 || i_text_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            r_ec <= '0;
        end else if (i_accept) begin
            r_pc <= n_pc;
            r_ec <= n_ec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

FILE: rtl/core/sfr_back.sv
`timescale 1ns / 1ps
// ============================================================================
// sfr_back
// Walks one queued command a word per cycle while the result queue has room:
// text bytes, then replacement bytes, or a bare end marker.
// ============================================================================
module sfr_back #(
    parameter int MAX_REPLACE_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  sfr_pkg::t_cmd                   i_cmd,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_replace_pattern,
    input  logic                            i_out_full,
    output logic                            o_cmd_pop,
    output logic                            o_res_push,
    output sfr_pkg::t_result                o_res
);

    localparam int IW = sfr_pkg::IDX_W;

    logic [IW-1:0] r_idx;
    logic [IW-1:0] rj;
    logic          last_one;
    logic          fire;

    assign last_one = (i_cmd.emit_cnt == '0) ||
                      ({1'b0, r_idx} == i_cmd.emit_cnt - 1'b1);
    assign fire     = i_cmd_valid && !i_out_full;
    assign rj       = r_idx - i_cmd.shift_cnt[IW-1:0];

    always_comb begin
        o_res = '0;
        if (i_cmd.emit_cnt != '0) begin
            o_res.byte_present = 1'b1;
            if ({1'b0, r_idx} < i_cmd.shift_cnt) begin
                o_res.result_byte = i_cmd.text[r_idx];
            end else begin
                for (int i = 0; i < MAX_REPLACE_BYTES; i++) begin
                    if (IW'(i) == rj) begin
                        o_res.result_byte = i_replace_pattern[8*i +: 8];
                    end
                end
            end
        end
        o_res.result_last = i_cmd.last && last_one;
    end

    assign o_res_push = fire;
    assign o_cmd_pop  = fire && last_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= last_one ? '0 : r_idx + 1'b1;
        end
    end

endmodule

FILE: rtl/core/sfr_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// sfr_checker
// Port-level checks of the find-and-replace core, bound to the top level.
// ============================================================================
module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_result_byte,
    input logic       o_byte_present,
    input logic       o_result_last
);

    // both queues come out of reset drained
    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not drained after reset");

    // a bare marker only ever closes a text
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_present |-> o_result_last)
        else $error("bare marker without last");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_present |-> o_result_byte == 8'h00)
        else $error("bare marker with nonzero byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result_byte) &&
        $stable(o_byte_present) && $stable(o_result_last))
        else $error("stalled result word changed");

endmodule

bind stream_find_and_replace_core sfr_checker u_sfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_result_byte  (o_result_byte),
    .o_byte_present (o_byte_present),
    .o_result_last  (o_result_last)
);

FILE: test/stream_find_and_replace_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// stream_find_and_replace_core_tb
// Self-checking bench for the streaming find-and-replace core.
// ============================================================================
// A short directed table covers reset defaults, byte extremes, case folding,
// deletion, the output limit, oversized lengths, a find change mid-text and
// the eight-word cap. Random register settings follow, each with texts built
// mostly from whole and partial copies of the find pattern, plus noise bytes.
// Every accepted input word runs through a local rewrite model whose output
// words, or a typed row's word, are queued and checked field by field on pop.
// Both queue sides idle at random, except for one stretch without gaps.
// ============================================================================
module stream_find_and_replace_core_tb;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 32;
    localparam int RAND_WORDS     = 145;
    localparam int ERR_REPORT_MAX = 100;
    localparam int WIN_DEPTH      = 8;

    localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [31:0]                   ALPHABET     = "abAB";

    typedef enum logic {ROW_WRITE, ROW_TEXT} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        logic [sfr_pkg::CFG_IDX_W-1:0]  idx;
        logic [sfr_pkg::CFG_DATA_W-1:0] data;
        logic [7:0]                     tbyte;
        logic                           tlast;
        bit                             typed;
        sfr_pkg::t_result               want;
    } t_stim_row;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           push        = 1'b0;
    logic [7:0]                     i_text_byte = '0;
    logic                           i_text_last = 1'b0;
    logic                           pop         = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           full;
    logic                           empty;
    logic [7:0]                     o_result_byte;
    logic                           o_byte_present;
    logic                           o_result_last;

    stream_find_and_replace_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_text_byte    (i_text_byte),
        .i_text_last    (i_text_last),
        .empty          (empty),
        .pop            (pop),
        .o_result_byte  (o_result_byte),
        .o_byte_present (o_byte_present),
        .o_result_last  (o_result_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register mirror and rewrite state
    logic [63:0] m_find;
    logic [63:0] m_repl;
    logic [3:0]  m_flen;
    logic [3:0]  m_rlen;
    logic        m_fold;
    logic [15:0] m_limit;
    logic [7:0]  win [WIN_DEPTH];
    int unsigned win_cnt;
    logic [15:0] sent_cnt;

    sfr_pkg::t_result step_out [$];
    sfr_pkg::t_result rewrite_q [$];
    t_stim_row        dir_table [$];
    logic [7:0]       text_buf [$];

    bit          quiet;
    int unsigned fail_cnt;
    int unsigned words_sent;
    int unsigned rand_words;
    int unsigned texts_sent;
    int unsigned settings_cnt;
    int unsigned results_checked;
    int unsigned cycle_cnt;

    function automatic logic [7:0] fold_ch(input logic [7:0] c);
        if (m_fold && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic void mirror_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [63:0] data);
        case (idx)
            sfr_pkg::CFG_FIND_PATTERN:    m_find  = data;
            sfr_pkg::CFG_FIND_LENGTH:     m_flen  = data[3:0];
            sfr_pkg::CFG_REPLACE_PATTERN: m_repl  = data;
            sfr_pkg::CFG_REPLACE_LENGTH:  m_rlen  = data[3:0];
            sfr_pkg::CFG_IGNORE_CASE:     m_fold  = data[0];
            sfr_pkg::CFG_OUTPUT_LIMIT:    m_limit = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        sfr_pkg::t_result r;
        if (m_limit != 16'd0 && sent_cnt >= m_limit - 16'd1) begin
            return;
        end
        if (step_out.size() >= sfr_pkg::MAX_RESULTS) begin
            return;
        end
        r.result_byte  = b;
        r.byte_present = 1'b1;
        r.result_last  = 1'b0;
        step_out.push_back(r);
        if (sent_cnt != 16'hFFFF) begin
            sent_cnt = sent_cnt + 16'd1;
        end
    endfunction

    function automatic void shift_front();
        int unsigned i;
        if (win_cnt == 0) begin
            return;
        end
        emit_byte(win[0]);
        for (i = 1; i < win_cnt && i < WIN_DEPTH; i++) begin
            win[i-1] = win[i];
        end
        win_cnt--;
    endfunction

    function automatic bit window_hit();
        int unsigned i;
        for (i = 0; i < win_cnt && i < WIN_DEPTH; i++) begin
            if (fold_ch(win[i]) != fold_ch(m_find[8*i +: 8])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // words produced by one text word, left in step_out
    function automatic void rewrite_step(input logic [7:0] b, input logic last);
        int unsigned      flen;
        int unsigned      rlen;
        int unsigned      i;
        sfr_pkg::t_result r;
        step_out.delete();
        flen = (m_flen > 4'd8) ? 8 : m_flen;
        rlen = (m_rlen > 4'd8) ? 8 : m_rlen;
        if (flen == 0) begin
            while (win_cnt > 0) begin
                shift_front();
            end
            emit_byte(b);
        end else begin
            if (win_cnt >= WIN_DEPTH) begin
                shift_front();
            end
            win[win_cnt] = b;
            win_cnt++;
            while (win_cnt > 0) begin
                if (window_hit()) begin
                    if (win_cnt == flen) begin
                        for (i = 0; i < rlen; i++) begin
                            emit_byte(m_repl[8*i +: 8]);
                        end
                        win_cnt = 0;
                        break;
                    end
                    if (win_cnt < flen) begin
                        break;
                    end
                end
                shift_front();
            end
        end
        if (last) begin
            while (win_cnt > 0) begin
                shift_front();
            end
            if (step_out.size() == 0) begin
                r.result_byte  = 8'h00;
                r.byte_present = 1'b0;
                r.result_last  = 1'b1;
                step_out.push_back(r);
            end else begin
                step_out[step_out.size()-1].result_last = 1'b1;
            end
            for (i = 0; i < WIN_DEPTH; i++) begin
                win[i] = 8'h00;
            end
            win_cnt  = 0;
            sent_cnt = 16'd0;
        end
    endfunction

    function automatic void add_write(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [63:0] data);
        t_stim_row row;
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.data  = data;
        row.tbyte = '0;
        row.tlast = 1'b0;
        row.typed = 1'b0;
        row.want  = '0;
        dir_table.push_back(row);
    endfunction

    function automatic void add_text(input logic [7:0] b, input logic last,
                                     input bit typed, input sfr_pkg::t_result want);
        t_stim_row row;
        row.kind  = ROW_TEXT;
        row.idx   = '0;
        row.data  = '0;
        row.tbyte = b;
        row.tlast = last;
        row.typed = typed;
        row.want  = want;
        dir_table.push_back(row);
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            && $urandom_range(0, 3) == 0) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [63:0] pad_bits(input logic [63:0] v, input int unsigned w);
        logic [63:0] junk;
        if ($urandom_range(0, 1) == 0) begin
            return v;
        end
        junk = {$urandom, $urandom};
        junk = junk & ~((64'd1 << w) - 64'd1);
        return junk | v;
    endfunction

    // texts built mostly from whole and partial copies of the find pattern
    function automatic void build_text();
        int unsigned flen;
        int unsigned parts;
        int unsigned k;
        int unsigned j;
        int unsigned n;
        int unsigned r;
        text_buf.delete();
        flen  = (m_flen > 4'd8) ? 8 : m_flen;
        parts = $urandom_range(1, 5);
        for (k = 0; k < parts && text_buf.size() < 16; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12 || flen == 0) begin
                text_buf.push_back(8'($urandom_range(0, 255)));
            end else if (r < 50) begin
                for (j = 0; j < flen; j++) begin
                    text_buf.push_back(flip_case(m_find[8*j +: 8]));
                end
            end else if (r < 70) begin
                n = $urandom_range(1, flen);
                for (j = 0; j < n; j++) begin
                    text_buf.push_back(flip_case(m_find[8*j +: 8]));
                end
            end else begin
                n = $urandom_range(0, flen - 1);
                text_buf.push_back(flip_case(m_find[8*n +: 8]));
            end
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last,
                             input bit typed, input sfr_pkg::t_result want);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_text_byte <= b;
        i_text_last <= last;
        @(posedge i_clk);
        while (full !== 1'b0) begin
            @(posedge i_clk);
        end
        rewrite_step(b, last);
        if (typed) begin
            rewrite_q.push_back(want);
        end else begin
            foreach (step_out[k]) begin
                rewrite_q.push_back(step_out[k]);
            end
        end
        words_sent++;
        if (last) begin
            texts_sent++;
        end
    endtask

    task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        push <= 1'b0;
        while (rewrite_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror_reg(idx, data);
    endtask

    task automatic random_settings();
        logic [63:0] pat;
        int unsigned r;
        int unsigned i;
        logic [3:0]  flen;
        logic [3:0]  rlen;
        logic [15:0] lim;
        for (i = 0; i < 8; i++) begin
            if ($urandom_range(0, 99) < 70) begin
                pat[8*i +: 8] = ALPHABET[8*$urandom_range(0, 3) +: 8];
            end else begin
                pat[8*i +: 8] = 8'($urandom_range(0, 255));
            end
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            flen = 4'd0;
        end else if (r < 80) begin
            flen = 4'($urandom_range(1, 4));
        end else if (r < 95) begin
            flen = 4'($urandom_range(5, 8));
        end else begin
            flen = 4'($urandom_range(9, 15));
        end
        rlen = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                            : 4'($urandom_range(9, 15));
        r = $urandom_range(0, 99);
        if (r < 55) begin
            lim = 16'd0;
        end else if (r < 90) begin
            lim = 16'($urandom_range(1, 16));
        end else if (r < 95) begin
            lim = 16'hFFFF;
        end else begin
            lim = 16'($urandom_range(17, 65535));
        end
        write_reg(sfr_pkg::CFG_FIND_PATTERN, pat);
        write_reg(sfr_pkg::CFG_FIND_LENGTH, pad_bits(64'(flen), 4));
        write_reg(sfr_pkg::CFG_REPLACE_PATTERN, {$urandom, $urandom});
        write_reg(sfr_pkg::CFG_REPLACE_LENGTH, pad_bits(64'(rlen), 4));
        write_reg(sfr_pkg::CFG_IGNORE_CASE, pad_bits(64'($urandom_range(0, 1)), 1));
        write_reg(sfr_pkg::CFG_OUTPUT_LIMIT, pad_bits(64'(lim), 16));
        if ($urandom_range(0, 9) == 0) begin
            write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      {$urandom, $urandom});
        end
        settings_cnt++;
    endtask

    function automatic void report_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (got !== want) begin
            if (fail_cnt < ERR_REPORT_MAX) begin
                $error("%s: expected %0h, got %0h", name, want, got);
            end
            fail_cnt++;
        end
    endfunction

    function automatic void check_result();
        sfr_pkg::t_result want;
        if (rewrite_q.size() == 0) begin
            if (fail_cnt < ERR_REPORT_MAX) begin
                $error("result word with none expected: byte %0h present %0b last %0b",
                       o_result_byte, o_byte_present, o_result_last);
            end
            fail_cnt++;
            return;
        end
        want = rewrite_q.pop_front();
        report_field("result_byte", want.result_byte, o_result_byte);
        report_field("byte_present", 8'(want.byte_present), 8'(o_byte_present));
        report_field("result_last", 8'(want.result_last), 8'(o_result_last));
        results_checked++;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            check_result();
        end
        pop <= quiet || ($urandom_range(0, 99) >= 7);
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d words still expected",
                 cycle_cnt, rewrite_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int unsigned k;
        m_find   = '0;
        m_repl   = '0;
        m_flen   = '0;
        m_rlen   = '0;
        m_fold   = 1'b0;
        m_limit  = '0;
        win_cnt  = 0;
        sent_cnt = '0;
        for (k = 0; k < WIN_DEPTH; k++) begin
            win[k] = 8'h00;
        end
        quiet           = 1'b0;
        fail_cnt        = 0;
        words_sent      = 0;
        rand_words      = 0;
        texts_sent      = 0;
        settings_cnt    = 1;
        results_checked = 0;

        // reset defaults: pass through
        add_text(8'h00, 1'b0, 1'b1, {8'h00, 1'b1, 1'b0});
        add_text(8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b1});
        // "abc" -> "XY"
        add_write(sfr_pkg::CFG_FIND_PATTERN, 64'h0000_0000_0063_6261);
        add_write(sfr_pkg::CFG_FIND_LENGTH, 64'd3);
        add_write(sfr_pkg::CFG_REPLACE_PATTERN, 64'h0000_0000_0000_5958);
        add_write(sfr_pkg::CFG_REPLACE_LENGTH, 64'd2);
        add_text("a", 1'b0, 1'b0, '0);
        add_text("b", 1'b0, 1'b0, '0);
        add_text("c", 1'b0, 1'b0, '0);
        add_text("a", 1'b0, 1'b0, '0);
        add_text("b", 1'b1, 1'b0, '0);
        add_text("z", 1'b1, 1'b1, {8'h7A, 1'b1, 1'b1});
        // case folding
        add_write(sfr_pkg::CFG_IGNORE_CASE, 64'd1);
        add_text("A", 1'b0, 1'b0, '0);
        add_text("B", 1'b0, 1'b0, '0);
        add_text("C", 1'b1, 1'b0, '0);
        // deletion leaves only the end marker
        add_write(sfr_pkg::CFG_REPLACE_LENGTH, 64'd0);
        add_text("a", 1'b0, 1'b0, '0);
        add_text("b", 1'b0, 1'b0, '0);
        add_text("c", 1'b1, 1'b1, {8'h00, 1'b0, 1'b1});
        // limit of one drops everything
        add_write(sfr_pkg::CFG_OUTPUT_LIMIT, 64'd1);
        add_text("q", 1'b1, 1'b1, {8'h00, 1'b0, 1'b1});
        add_write(sfr_pkg::CFG_OUTPUT_LIMIT, 64'hFFFF);
        add_write(CFG_SPARE_LO, '1);
        add_write(CFG_SPARE_HI, '1);
        // oversized lengths saturate to eight
        add_write(sfr_pkg::CFG_FIND_PATTERN, '1);
        add_write(sfr_pkg::CFG_FIND_LENGTH, 64'd15);
        add_write(sfr_pkg::CFG_REPLACE_PATTERN, 64'h0807_0605_0403_0201);
        add_write(sfr_pkg::CFG_REPLACE_LENGTH, 64'd15);
        add_write(sfr_pkg::CFG_IGNORE_CASE, 64'd0);
        for (k = 0; k < 7; k++) begin
            add_text(8'hFF, 1'b0, 1'b0, '0);
        end
        // shorter find mid-text, full window spills past the word cap
        add_write(sfr_pkg::CFG_FIND_LENGTH, 64'd1);
        add_text(8'hFF, 1'b0, 1'b0, '0);
        add_text(8'hFF, 1'b1, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[ri]) begin
            if (dir_table[ri].kind == ROW_WRITE) begin
                write_reg(dir_table[ri].idx, dir_table[ri].data);
            end else begin
                send_word(dir_table[ri].tbyte, dir_table[ri].tlast,
                          dir_table[ri].typed, dir_table[ri].want);
            end
        end

        while (rand_words < RAND_WORDS) begin
            random_settings();
            repeat ($urandom_range(2, 5)) begin
                quiet = (rand_words >= 60 && rand_words < 110);
                build_text();
                for (k = 0; k < text_buf.size(); k++) begin
                    send_word(text_buf[k], k == text_buf.size() - 1, 1'b0, '0);
                    rand_words++;
                end
            end
        end
        quiet = 1'b0;

        push <= 1'b0;
        while (rewrite_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d text words in %0d texts over %0d register settings",
                 words_sent, texts_sent, settings_cnt);
        $display("checked %0d result words, %0d mismatches", results_checked, fail_cnt);
        if (fail_cnt == 0 && rewrite_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
